### rtl/safi_pkg.sv
// Shared widths, register indexes and mode codes of the sprite animation frame index block.
`default_nettype none

package safi_pkg;

  localparam int STEP_W      = 32;
  localparam int DUR_W       = 16;
  localparam int FPS_W       = 16;
  localparam int START_W     = 32;
  localparam int COUNT_W     = 9;
  localparam int FRAME_W     = 8;
  localparam int MODE_W      = 2;
  localparam int NOW_W       = STEP_W + DUR_W;
  localparam int DELTA_W     = NOW_W + 1;
  localparam int MPLIER_W    = 16;
  localparam int PROD_W      = DELTA_W + MPLIER_W;
  localparam int FRAC_SHIFT  = 24;
  localparam int Q_W         = PROD_W - FRAC_SHIFT;
  localparam int FI_W        = Q_W + 1;
  localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
  localparam int MAX_FRAMES_DEF = 256;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ANIM_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FPS           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DURATION = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_STOPPED = 2'd0,
    MODE_LOOP    = 2'd1,
    MODE_CLAMP   = 2'd2
  } mode_e;

endpackage

`default_nettype wire

### rtl/safi_in_if.sv
// Input channel carrying one world step count per update request.
`default_nettype none

interface safi_in_if import safi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] world_step;

  modport source (output valid, output world_step, input ready);
  modport sink (input valid, input world_step, output ready);
endinterface

`default_nettype wire

### rtl/safi_out_if.sv
// Output channel carrying the frame index and animating flag of one update.
`default_nettype none

interface safi_out_if import safi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_idx;
  logic               animating;

  modport source (output valid, output frame_idx, output animating, input ready);
  modport sink (input valid, input frame_idx, input animating, output ready);
endinterface

`default_nettype wire

### rtl/safi_serial_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
`default_nettype none

module safi_serial_mul import safi_pkg::*; #(
  parameter int MCAND_W = DELTA_W,
  parameter int MUL_W   = MPLIER_W
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [MCAND_W-1:0]    mcand_i,
  input  wire logic        [MUL_W-1:0]      mplier_i,
  output logic                              done_o,
  output logic signed [MCAND_W+MUL_W-1:0]   product_o
);

  localparam int CNT_W = $clog2(MUL_W + 1);

  logic signed [MCAND_W:0]   acc_q, acc_d, sum;
  logic signed [MCAND_W-1:0] mcand_q;
  logic        [MUL_W-1:0]   lo_q;
  logic        [CNT_W-1:0]   cnt_q;
  logic                      done_q;

  always_comb begin
    sum   = acc_q + (lo_q[0] ? {mcand_q[MCAND_W-1], mcand_q} : '0);
    acc_d = sum >>> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(MUL_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= '0;
      mcand_q <= mcand_i;
      lo_q    <= mplier_i;
    end else if (cnt_q != '0) begin
      acc_q <= acc_d;
      lo_q  <= {sum[0], lo_q[MUL_W-1:1]};
    end
  end

  assign done_o    = done_q;
  assign product_o = {acc_q[MCAND_W-1:0], lo_q};

endmodule

`default_nettype wire

### rtl/safi_serial_mod.sv
// Bit-serial remainder unit: floor modulo of a signed value by a small frame count.
`default_nettype none

module safi_serial_mod import safi_pkg::*; #(
  parameter int VAL_W = FI_W,
  parameter int N_W   = COUNT_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [VAL_W-1:0] value_i,
  input  wire logic [N_W-1:0]   modulus_i,
  output logic                  done_o,
  output logic [N_W-1:0]        rem_o
);

  localparam int CNT_W = $clog2(VAL_W);

  logic [N_W-1:0]   rem_q, rem_d, n_q;
  logic [VAL_W-2:0] sh_q;
  logic [N_W:0]     trial, reduced;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  // The sign bit carries weight minus two to the top power, so the running
  // remainder starts at minus one modulo the count when it is set.
  always_comb begin
    trial   = {rem_q, sh_q[VAL_W-2]};
    reduced = trial - {1'b0, n_q};
    rem_d   = (trial >= {1'b0, n_q}) ? reduced[N_W-1:0] : trial[N_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(VAL_W - 1);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= value_i[VAL_W-1] ? (modulus_i - N_W'(1)) : '0;
      sh_q  <= value_i[VAL_W-2:0];
      n_q   <= modulus_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[VAL_W-3:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### rtl/sprite_animation_frame_index_core.sv
// Sprite animation frame index core: sequencer, configuration registers and result register.
// While stopped an update goes straight to the result; otherwise the time comes from a
// bit-serial multiplier that computes step times duration and then elapsed time times rate,
// one multiplier bit per cycle. Loop mode adds a bit-serial remainder by the frame count.
// One update is processed at a time; the next one is taken while the previous result still
// waits in the output register, and a result that is still not taken holds the following
// update in its done state.
`default_nettype none

module sprite_animation_frame_index_core import safi_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  safi_in_if.sink                    in_if,
  safi_out_if.source                 out_if,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CAP = (MAX_FRAMES < COUNT_MAX) ? MAX_FRAMES : COUNT_MAX;
  localparam int N_W = $clog2(CAP + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_NOW,
    ST_MUL_RATE,
    ST_INDEX,
    ST_WRAP,
    ST_DONE
  } state_e;

  state_e                    state_q;
  mode_e                     active_mode_q;
  logic [FRAME_W-1:0]        current_frame_q;
  logic                      mul_start_q, mod_start_q;
  logic                      out_valid_q, out_anim_q;
  logic [FRAME_W-1:0]        out_frame_q;

  logic [COUNT_W-1:0]        frame_count_q;
  logic signed [FPS_W-1:0]   fps_q;
  logic [START_W-1:0]        start_time_q;
  logic [DUR_W-1:0]          step_dur_q;

  logic [STEP_W-1:0]         step_q;
  logic signed [DELTA_W-1:0] delta_q, delta_d;
  logic [FI_W-1:0]           fi_q, fi_d;

  logic [N_W-1:0]            n_eff, n_last;
  logic                      fps_neg;
  logic [FPS_W-1:0]          fps_mag;
  logic [Q_W-1:0]            q_frames;
  logic                      below, above;

  logic signed [DELTA_W-1:0] mul_mcand;
  logic [MPLIER_W-1:0]       mul_mplier;
  logic                      mul_done;
  logic signed [PROD_W-1:0]  mul_product;
  logic                      mod_done;
  logic [N_W-1:0]            mod_rem;

  always_comb begin
    if (frame_count_q == '0) begin
      n_eff = N_W'(1);
    end else if (int'(frame_count_q) > CAP) begin
      n_eff = N_W'(CAP);
    end else begin
      n_eff = N_W'(frame_count_q);
    end
    n_last   = n_eff - N_W'(1);
    fps_neg  = fps_q[FPS_W-1];
    fps_mag  = fps_neg ? FPS_W'(-fps_q) : FPS_W'(fps_q);
    q_frames = mul_product[PROD_W-1:FRAC_SHIFT];
    delta_d  = DELTA_W'({1'b0, mul_product[NOW_W-1:0]}) - DELTA_W'(start_time_q);
    fi_d     = fps_neg ? (FI_W'(n_last) - {q_frames[Q_W-1], q_frames})
                       : {q_frames[Q_W-1], q_frames};
    below    = fi_q[FI_W-1];
    above    = !below && (fi_q[FI_W-2:0] >= (FI_W-1)'(n_eff));
    mul_mcand  = (state_q == ST_MUL_RATE) ? delta_q : DELTA_W'(step_q);
    mul_mplier = (state_q == ST_MUL_RATE) ? fps_mag : step_dur_q;
  end

  safi_serial_mul #(
    .MCAND_W (DELTA_W),
    .MUL_W   (MPLIER_W)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start_q),
    .mcand_i   (mul_mcand),
    .mplier_i  (mul_mplier),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  safi_serial_mod #(
    .VAL_W (FI_W),
    .N_W   (N_W)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start_q),
    .value_i   (fi_q),
    .modulus_i (n_eff),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= COUNT_W'(1);
      fps_q         <= '0;
      start_time_q  <= '0;
      step_dur_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_COUNT:   frame_count_q <= cfg_data_i[COUNT_W-1:0];
        REG_FPS:           fps_q         <= cfg_data_i[FPS_W-1:0];
        REG_START_TIME:    start_time_q  <= cfg_data_i[START_W-1:0];
        REG_STEP_DURATION: step_dur_q    <= cfg_data_i[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_if.valid) begin
      step_q <= in_if.world_step;
    end
    if (state_q == ST_MUL_NOW && mul_done) begin
      delta_q <= delta_d;
    end
    if (state_q == ST_MUL_RATE && mul_done) begin
      fi_q <= fi_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      active_mode_q   <= MODE_STOPPED;
      current_frame_q <= '0;
      mul_start_q     <= 1'b0;
      mod_start_q     <= 1'b0;
      out_valid_q     <= 1'b0;
      out_frame_q     <= '0;
      out_anim_q      <= 1'b0;
    end else begin
      mul_start_q <= ((state_q == ST_IDLE) && in_if.valid && (active_mode_q != MODE_STOPPED))
                     || ((state_q == ST_MUL_NOW) && mul_done);
      mod_start_q <= (state_q == ST_INDEX) && (active_mode_q == MODE_LOOP);
      if (state_q == ST_DONE && (!out_valid_q || out_if.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && cfg_idx_i == REG_ANIM_MODE) begin
        unique case (cfg_data_i[MODE_W-1:0])
          MODE_LOOP:  active_mode_q <= MODE_LOOP;
          MODE_CLAMP: active_mode_q <= MODE_CLAMP;
          default:    active_mode_q <= MODE_STOPPED;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_if.valid) begin
            if (active_mode_q == MODE_STOPPED) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_MUL_NOW;
            end
          end
        end
        ST_MUL_NOW: begin
          if (mul_done) begin
            state_q <= ST_MUL_RATE;
          end
        end
        ST_MUL_RATE: begin
          if (mul_done) begin
            state_q <= ST_INDEX;
          end
        end
        ST_INDEX: begin
          if (active_mode_q == MODE_LOOP) begin
            state_q <= ST_WRAP;
          end else begin
            priority if (below) begin
              current_frame_q <= '0;
              if (fps_neg || fps_q == '0) begin
                active_mode_q <= MODE_STOPPED;
              end
            end else if (above) begin
              current_frame_q <= FRAME_W'(n_last);
              if (!fps_neg) begin
                active_mode_q <= MODE_STOPPED;
              end
            end else begin
              current_frame_q <= fi_q[FRAME_W-1:0];
            end
            state_q <= ST_DONE;
          end
        end
        ST_WRAP: begin
          if (mod_done) begin
            current_frame_q <= FRAME_W'(mod_rem);
            state_q         <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_if.ready) begin
            out_frame_q <= current_frame_q;
            out_anim_q  <= (active_mode_q != MODE_STOPPED);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_if.ready      = (state_q == ST_IDLE);
  assign out_if.valid     = out_valid_q;
  assign out_if.frame_idx = out_frame_q;
  assign out_if.animating = out_anim_q;

endmodule

`default_nettype wire

### rtl/safi_checker.sv
// Port-level checks of the frame index core, bound to its top level.
`default_nettype none

module safi_checker import safi_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [FRAME_W-1:0] out_frame_idx_i,
  input wire logic               out_animating_i
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_frame_idx_i) && $stable(out_animating_i))
    else $error("stalled result changed");

  // Only one update is in flight: the input closes right after a transfer.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transfer");

  // No result is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

  // A result cannot appear in the cycle right after an update is taken.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result appeared too early");

endmodule

bind sprite_animation_frame_index_core safi_checker u_safi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .out_frame_idx_i (out_if.frame_idx),
  .out_animating_i (out_if.animating)
);

`default_nettype wire

### tb/sv/sprite_animation_frame_index_core_tb.sv
// Self-checking testbench for the sprite animation frame index core with a built-in frame predictor.
module sprite_animation_frame_index_core_tb import safi_pkg::*;;

  localparam logic [MODE_W-1:0]    MODE_UNUSED      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_idx;
    logic               animating;
  } frame_result_t;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC,
    READY_LONG_STALLS
  } ready_style_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  safi_in_if  in_ch ();
  safi_out_if out_ch ();

  sprite_animation_frame_index_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  mode_e                     live_mode   = MODE_STOPPED;
  logic [COUNT_W-1:0]        count_q     = 9'd1;
  logic signed [FPS_W-1:0]   fps_q       = '0;
  logic [START_W-1:0]        start_q     = '0;
  logic [DUR_W-1:0]          dur_q       = '0;
  logic [FRAME_W-1:0]        shown_frame = '0;

  frame_result_t pending_frames[$];
  int            mismatches  = 0;
  int            steps_sent  = 0;
  int            burst_left  = 0;

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ANIM_MODE: begin
        live_mode = (data[MODE_W-1:0] == MODE_UNUSED) ? MODE_STOPPED : mode_e'(data[MODE_W-1:0]);
      end
      REG_FRAME_COUNT:   count_q = data[COUNT_W-1:0];
      REG_FPS:           fps_q = data[FPS_W-1:0];
      REG_START_TIME:    start_q = data[START_W-1:0];
      REG_STEP_DURATION: dur_q = data[DUR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic frame_result_t advance_animation(input logic [STEP_W-1:0] step);
    longint        n;
    longint        fps;
    longint        now_t;
    longint        elapsed;
    longint        fi;
    frame_result_t res;
    n = longint'(count_q);
    if (n < 1) n = 1;
    if (n > longint'(MAX_FRAMES_DEF)) n = longint'(MAX_FRAMES_DEF);
    fps = longint'(fps_q);
    if (live_mode == MODE_LOOP || live_mode == MODE_CLAMP) begin
      now_t = 0;
      now_t[STEP_W-1:0] = step;
      now_t = now_t * longint'({1'b0, dur_q});
      elapsed = now_t - longint'({1'b0, start_q});
      if (fps >= 0) begin
        fi = (elapsed * fps) >>> FRAC_SHIFT;
      end else begin
        fi = n - ((elapsed * -fps) >>> FRAC_SHIFT) - 1;
      end
      if (live_mode == MODE_LOOP) begin
        if (fi < 0) fi = n - ((-fi) % n);
        fi = fi % n;
      end else begin
        if (fi < 0) begin
          fi = 0;
          if (fps <= 0) live_mode = MODE_STOPPED;
        end else if (fi >= n) begin
          fi = n - 1;
          if (fps >= 0) live_mode = MODE_STOPPED;
        end
      end
      shown_frame = fi[FRAME_W-1:0];
    end
    res.frame_idx = shown_frame;
    res.animating = (live_mode == MODE_LOOP || live_mode == MODE_CLAMP);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("result transfer with no pending update",
                        longint'(out_ch.frame_idx), 0);
      end else begin
        want = pending_frames.pop_front();
        if (out_ch.frame_idx !== want.frame_idx) begin
          report_mismatch("frame_idx", longint'(out_ch.frame_idx), longint'(want.frame_idx));
        end
        if (out_ch.animating !== want.animating) begin
          report_mismatch("animating", longint'(out_ch.animating), longint'(want.animating));
        end
      end
    end
  end

  initial begin : result_sink
    ready_style_e style;
    int           hold;
    int           stall;
    out_ch.ready <= 1'b0;
    style = READY_ALWAYS;
    hold = 0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold == 0) begin
        style = ready_style_e'($urandom_range(0, 3));
        hold = $urandom_range(50, 400);
      end
      hold--;
      case (style)
        READY_ALWAYS:   out_ch.ready <= 1'b1;
        READY_RANDOM:   out_ch.ready <= ($urandom_range(0, 9) < 7);
        READY_PERIODIC: out_ch.ready <= ((hold % 8) >= 3);
        default: begin
          if (stall > 0) begin
            stall--;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 15) == 0) stall = $urandom_range(5, 25);
          end
        end
      endcase
    end
  end

  task automatic send_step(input logic [STEP_W-1:0] step);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.world_step <= step;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    pending_frames.push_back(advance_animation(step));
    steps_sent++;
  endtask

  // The sender holds off until every pending result has been taken.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_frames.size() != 0);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
  endtask

  task automatic program_regs(input logic write_mode, input logic [MODE_W-1:0] mode,
                              input logic [COUNT_W-1:0] count, input logic [FPS_W-1:0] fps,
                              input logic [START_W-1:0] start, input logic [DUR_W-1:0] dur);
    if (write_mode) write_reg(REG_ANIM_MODE, CFG_DATA_W'(mode));
    write_reg(REG_FRAME_COUNT, CFG_DATA_W'(count));
    write_reg(REG_FPS, CFG_DATA_W'(fps));
    if ($urandom_range(0, 3) == 0) begin
      write_reg(REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2)), $urandom);
    end
    write_reg(REG_START_TIME, CFG_DATA_W'(start));
    write_reg(REG_STEP_DURATION, CFG_DATA_W'(dur));
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_step('0);
    send_step('1);
  endtask

  task automatic test_unused_mode();
    drain_results();
    program_regs(1'b1, MODE_UNUSED, 9'd8, 16'h0100, 32'h0000_0000, 16'h4000);
    send_step(32'd5);
  endtask

  task automatic test_loop_both_directions();
    drain_results();
    program_regs(1'b1, MODE_LOOP, 9'd5, 16'h1800, 32'h0001_0000, 16'h0444);
    send_step(32'd0);
    send_step(32'd60);
    send_step(32'd61);
    send_step(32'd100);
    send_step(32'd200);
    drain_results();
    program_regs(1'b1, MODE_LOOP, 9'd7, 16'h8000, 32'h0001_0000, 16'h0444);
    send_step(32'd0);
    send_step(32'd300);
  endtask

  task automatic test_zero_rate();
    drain_results();
    program_regs(1'b1, MODE_CLAMP, 9'd4, 16'h0000, 32'h0000_0000, 16'hFFFF);
    send_step('1);
    send_step(32'd3);
  endtask

  task automatic test_clamp_ends();
    drain_results();
    program_regs(1'b1, MODE_CLAMP, 9'd6, 16'h0400, 32'h0002_0000, 16'h8000);
    send_step(32'd0);
    send_step(32'd10);
    send_step(32'd4);
    drain_results();
    program_regs(1'b0, MODE_STOPPED, 9'd6, 16'h0200, 32'h0000_0000, 16'h8000);
    send_step(32'd1);
    drain_results();
    program_regs(1'b1, MODE_CLAMP, 9'd6, 16'hFC00, 32'h0002_0000, 16'h8000);
    send_step(32'd0);
    send_step(32'd5);
    send_step(32'd8);
  endtask

  task automatic test_count_limits();
    drain_results();
    program_regs(1'b1, MODE_LOOP, 9'd0, 16'h7FFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_step('1);
    drain_results();
    program_regs(1'b0, MODE_LOOP, 9'd511, 16'h7FFF, 32'h0000_0000, 16'hFFFF);
    send_step('1);
    drain_results();
    program_regs(1'b0, MODE_LOOP, 9'd256, 16'h0100, 32'h0000_8000, 16'h0000);
    send_step(32'd12345);
  endtask

  task automatic test_random_sequences(input int target);
    int                 first;
    int                 run_len;
    int                 stride;
    int                 pick;
    logic               write_mode;
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
    logic [FPS_W-1:0]   fps;
    logic [FPS_W-1:0]   mag;
    logic [START_W-1:0] start;
    logic [DUR_W-1:0]   dur;
    logic [STEP_W-1:0]  step;
    first = steps_sent;
    while (steps_sent - first < target) begin
      drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 45) mode = MODE_LOOP;
      else if (pick < 85) mode = MODE_CLAMP;
      else if (pick < 93) mode = MODE_STOPPED;
      else mode = MODE_UNUSED;
      write_mode = ($urandom_range(0, 9) != 0);

      pick = $urandom_range(0, 99);
      if (pick < 60) count = COUNT_W'($urandom_range(1, 16));
      else if (pick < 75) count = COUNT_W'($urandom_range(17, 256));
      else if (pick < 80) count = '0;
      else if (pick < 85) count = 9'd256;
      else count = COUNT_W'($urandom_range(257, 511));

      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        mag = FPS_W'($urandom_range(64, 8192));
        fps = $urandom_range(0, 1) ? -mag : mag;
      end else if (pick < 80) fps = '0;
      else if (pick < 85) fps = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      else fps = FPS_W'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 70) dur = DUR_W'($urandom_range(256, 4096));
      else if (pick < 75) dur = '0;
      else if (pick < 80) dur = '1;
      else dur = DUR_W'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 70) start = $urandom_range(0, 32'h00FF_FFFF);
      else if (pick < 75) start = '0;
      else if (pick < 80) start = '1;
      else start = $urandom;

      program_regs(write_mode, mode, count, fps, start, dur);

      stride = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 200) : $urandom_range(1, 8);
      step = (dur == 0) ? STEP_W'($urandom) : start / dur;
      step = step - STEP_W'($urandom_range(0, stride * 8));
      run_len = $urandom_range(8, 48);
      repeat (run_len) begin
        if ($urandom_range(0, 9) < 8) begin
          send_step(step);
          step = step + STEP_W'(stride);
        end else begin
          send_step($urandom);
        end
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.world_step <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_ANIM_MODE;
    cfg_data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_unused_mode();
    test_loop_both_directions();
    test_zero_rate();
    test_clamp_ends();
    test_count_limits();
    test_random_sequences(1250);
    drain_results();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(12 * 3_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/safi_pkg.sv
rtl/safi_in_if.sv
rtl/safi_out_if.sv
rtl/safi_serial_mul.sv
rtl/safi_serial_mod.sv
rtl/sprite_animation_frame_index_core.sv
rtl/safi_checker.sv
tb/sv/sprite_animation_frame_index_core_tb.sv
